FILE: hw/rtl/spf_pkg.sv
// package for the stepper position follower
// holds widths, action and register codes, result structs, and saturation and field helpers
// no dependencies
package spf_pkg;

    localparam int POS_WIDTH   = 24;
    localparam int FIELD_W     = 24;
    localparam int STEP_W      = 16;
    localparam int USABLE_W    = 22;
    localparam int EXT_W       = ((POS_WIDTH > FIELD_W) ? POS_WIDTH : FIELD_W) + 3;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [STEP_W-1:0]   MAX_STEP_RESET = STEP_W'(70);
    localparam logic [USABLE_W-1:0] USABLE_RESET   = USABLE_W'(4000);

    localparam logic signed [EXT_W-1:0] POS_MAX_X =
        {{(EXT_W-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [EXT_W-1:0] POS_MIN_X = ~POS_MAX_X;

    typedef enum logic [1:0] {
        ACT_STOP = 2'd0,
        ACT_HOLD = 2'd1,
        ACT_GOTO = 2'd2,
        ACT_JOG  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_MAX_STEP   = 2'd0,
        REG_USABLE     = 2'd1,
        REG_START_POS  = 2'd2,
        REG_UNUSED     = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] pos;
        logic signed [POS_WIDTH-1:0] tgt;
        logic                        known;
        logic                        busy;
    } t_step_res;

    typedef struct packed {
        logic signed [FIELD_W-1:0] position;
        logic signed [FIELD_W-1:0] target;
        logic                      known;
        logic                      busy_res;
    } t_result;

    // clip a wide value into the signed position range
    function automatic logic signed [POS_WIDTH-1:0] sat_pos(
        input logic signed [EXT_W-1:0] v
    );
        logic signed [EXT_W-1:0] c;
        begin
            if (v > POS_MAX_X) begin
                c = POS_MAX_X;
            end else if (v < POS_MIN_X) begin
                c = POS_MIN_X;
            end else begin
                c = v;
            end
            return c[POS_WIDTH-1:0];
        end
    endfunction

    // sign extend or truncate a position to the 24 bit port field
    function automatic logic signed [FIELD_W-1:0] to_field(
        input logic signed [POS_WIDTH-1:0] v
    );
        logic signed [EXT_W-1:0] t;
        begin
            t = EXT_W'(v);
            return t[FIELD_W-1:0];
        end
    endfunction

endpackage

FILE: hw/rtl/spf_calc.sv
// next-state logic for one control tick: zero-here, then stop/hold/goto/jog
// depends on spf_pkg
module spf_calc (
    input  logic signed [spf_pkg::POS_WIDTH-1:0] i_pos,
    input  logic signed [spf_pkg::POS_WIDTH-1:0] i_tgt,
    input  logic                                 i_known,
    input  logic [spf_pkg::STEP_W-1:0]           i_max_step,
    input  logic [spf_pkg::USABLE_W-1:0]         i_usable,
    input  logic [1:0]                           i_action,
    input  logic                                 i_zero_here,
    input  logic signed [spf_pkg::FIELD_W-1:0]   i_goal,
    output spf_pkg::t_step_res                   o_res
);
    import spf_pkg::*;

    logic signed [POS_WIDTH-1:0] pos0;
    logic signed [POS_WIDTH-1:0] tgt0;
    logic signed [POS_WIDTH-1:0] goal_s;
    logic signed [POS_WIDTH-1:0] tgt_sel;
    logic signed [POS_WIDTH-1:0] chase_pos;
    logic signed [POS_WIDTH-1:0] jog_pos;
    logic signed [EXT_W-1:0]     pos_x;
    logic signed [EXT_W-1:0]     lim_x;
    logic signed [EXT_W-1:0]     diff_x;
    logic signed [EXT_W-1:0]     d_x;
    logic signed [EXT_W-1:0]     u_x;
    logic signed [EXT_W-1:0]     jlo_x;
    logic signed [EXT_W-1:0]     jp_x;
    logic signed [EXT_W-1:0]     jc_x;
    t_action                     act;

    always_comb begin
        act    = t_action'(i_action);
        pos0   = i_zero_here ? '0 : i_pos;
        tgt0   = i_zero_here ? '0 : i_tgt;
        goal_s = sat_pos(EXT_W'(i_goal));

        pos_x  = EXT_W'(pos0);
        lim_x  = $signed(EXT_W'(i_max_step));

        // slew-limited move toward the target
        tgt_sel = (act == ACT_GOTO) ? goal_s : tgt0;
        diff_x  = EXT_W'(tgt_sel) - pos_x;
        if (diff_x > lim_x) begin
            d_x = lim_x;
        end else if (diff_x < -lim_x) begin
            d_x = -lim_x;
        end else begin
            d_x = diff_x;
        end
        chase_pos = sat_pos(pos_x + d_x);

        // jog: fixed step in goal direction, clamp to [-2*usable, usable]
        u_x   = $signed(EXT_W'(i_usable));
        jlo_x = -(u_x + u_x);
        jp_x  = (goal_s < 0) ? (pos_x - lim_x) : (pos_x + lim_x);
        if (jp_x > u_x) begin
            jc_x = u_x;
        end else if (jp_x < jlo_x) begin
            jc_x = jlo_x;
        end else begin
            jc_x = jp_x;
        end
        jog_pos = sat_pos(jc_x);

        o_res.known = i_known | i_zero_here;
        unique case (act) inside
            ACT_GOTO, ACT_HOLD: begin
                o_res.pos  = chase_pos;
                o_res.tgt  = tgt_sel;
                o_res.busy = (chase_pos != tgt_sel);
            end
            ACT_JOG: begin
                o_res.pos  = jog_pos;
                o_res.tgt  = jog_pos;
                o_res.busy = 1'b1;
            end
            default: begin
                o_res.pos  = pos0;
                o_res.tgt  = pos0;
                o_res.busy = 1'b0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/stepper_position_follower.sv
// top level of the stepper position follower: state, config registers, output skid
// depends on spf_pkg and spf_calc
//
//  channel   direction  handshake                   payload
//  tick in   in         i_in_valid / o_in_ready     i_action, i_zero_here, i_goal
//  result    out        o_out_valid / i_out_ready   o_position, o_target, o_known, o_busy_res
//  config    in         psel, penable, pwrite       paddr, pwdata, prdata, pready
//
// one tick per cycle while o_in_ready is high: state updates at the accepting edge, and the result
// is registered into the result register, or into the skid entry when the result register is held.
// a two-entry output buffer (result register plus skid) keeps o_in_ready registered;
// input stalls only when both entries hold results not yet taken.
// synchronous active-low reset clears position, target, known and the buffer valids.
module stepper_position_follower (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_action,
    input  logic                                 i_zero_here,
    input  logic signed [spf_pkg::FIELD_W-1:0]   i_goal,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [spf_pkg::FIELD_W-1:0]   o_position,
    output logic signed [spf_pkg::FIELD_W-1:0]   o_target,
    output logic                                 o_known,
    output logic                                 o_busy_res,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [spf_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [spf_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [spf_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import spf_pkg::*;

    logic [STEP_W-1:0]           r_max_step;
    logic [USABLE_W-1:0]         r_usable;
    logic signed [POS_WIDTH-1:0] r_start;
    logic signed [POS_WIDTH-1:0] r_pos;
    logic signed [POS_WIDTH-1:0] r_tgt;
    logic                        r_known;
    logic                        r_out_valid;
    logic                        r_skd_valid;
    t_result                     r_out;
    t_result                     r_skd;

    t_step_res                   step_res;
    t_result                     n_res;
    t_reg_idx                    reg_idx;
    logic                        cfg_wr;
    logic                        in_acc;
    logic                        out_take;
    logic signed [POS_WIDTH-1:0] n_start;

    assign pready      = 1'b1;
    assign reg_idx     = t_reg_idx'(paddr[3:2]);
    assign cfg_wr      = psel & penable & pwrite & pready;
    assign o_in_ready  = ~r_skd_valid;
    assign in_acc      = i_in_valid & o_in_ready;
    assign out_take    = r_out_valid & i_out_ready;
    assign n_start     = sat_pos(EXT_W'($signed(pwdata[FIELD_W-1:0])));

    spf_calc u_calc (
        .i_pos       (r_pos),
        .i_tgt       (r_tgt),
        .i_known     (r_known),
        .i_max_step  (r_max_step),
        .i_usable    (r_usable),
        .i_action    (i_action),
        .i_zero_here (i_zero_here),
        .i_goal      (i_goal),
        .o_res       (step_res)
    );

    always_comb begin
        n_res.position = to_field(step_res.pos);
        n_res.target   = to_field(step_res.tgt);
        n_res.known    = step_res.known;
        n_res.busy_res = step_res.busy;
    end

    always_comb begin
        unique case (reg_idx)
            REG_MAX_STEP:  prdata = APB_DATA_W'(r_max_step);
            REG_USABLE:    prdata = APB_DATA_W'(r_usable);
            REG_START_POS: prdata = APB_DATA_W'(unsigned'(to_field(r_start)));
            default:       prdata = '0;
        endcase
    end

    // config registers and tick state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_step <= MAX_STEP_RESET;
            r_usable   <= USABLE_RESET;
            r_start    <= '0;
            r_pos      <= '0;
            r_tgt      <= '0;
            r_known    <= 1'b0;
        end else begin
            if (in_acc) begin
                r_pos   <= step_res.pos;
                r_tgt   <= step_res.tgt;
                r_known <= step_res.known;
            end
            if (cfg_wr) begin
                case (reg_idx)
                    REG_MAX_STEP: r_max_step <= pwdata[STEP_W-1:0];
                    REG_USABLE:   r_usable   <= pwdata[USABLE_W-1:0];
                    REG_START_POS: begin
                        r_start <= n_start;
                        r_pos   <= n_start;
                        r_tgt   <= n_start;
                    end
                    default: ;
                endcase
            end
        end
    end

    // result register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            if (out_take) begin
                r_skd_valid <= 1'b0;
            end
        end else if (in_acc) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skd_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (out_take) begin
                r_out <= r_skd;
            end
        end else if (in_acc) begin
            if (!r_out_valid || out_take) begin
                r_out <= n_res;
            end else begin
                r_skd <= n_res;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_position  = r_out.position;
    assign o_target    = r_out.target;
    assign o_known     = r_out.known;
    assign o_busy_res  = r_out.busy_res;

endmodule

FILE: tb/sv/stepper_position_follower_test.sv
// self-checking testbench for stepper_position_follower: random and directed control ticks,
// apb register writes between phases, results checked against an in-bench motion predictor
// depends on spf_pkg and the stepper_position_follower rtl
module stepper_position_follower_test;
    import spf_pkg::*;

    typedef struct {
        t_action                   act;
        logic                      zero;
        logic signed [FIELD_W-1:0] goal;
    } t_pending_tick;

    logic                      i_clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      tick_valid = 1'b0;
    logic                      in_ready;
    logic [1:0]                tick_action = 2'd0;
    logic                      tick_zero = 1'b0;
    logic signed [FIELD_W-1:0] tick_goal = '0;
    logic                      out_valid;
    logic                      res_ready = 1'b0;
    logic signed [FIELD_W-1:0] out_position;
    logic signed [FIELD_W-1:0] out_target;
    logic                      out_known;
    logic                      out_busy;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr = '0;
    logic [APB_DATA_W-1:0]     pwdata = '0;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;

    t_pending_tick tick_q[$];
    t_result       motion_want_q[$];
    int            fail_count = 0;
    logic          tick_taken = 1'b0;

    // predictor state and its copy of the registers
    longint        mdl_pos;
    longint        mdl_tgt;
    logic          mdl_known;
    logic [15:0]   mdl_step;
    logic [21:0]   mdl_travel;

    // sender burst pattern
    int            burst_left = 0;
    int            gap_left = 0;

    // receiver stall pattern and long hold-off
    int            hold_req = 0;
    int            hold_seen = 0;
    int            hold_left = 0;
    int            rx_mode = 0;
    int            rx_mode_left = 0;

    stepper_position_follower u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (tick_valid),
        .o_in_ready  (in_ready),
        .i_action    (tick_action),
        .i_zero_here (tick_zero),
        .i_goal      (tick_goal),
        .o_out_valid (out_valid),
        .i_out_ready (res_ready),
        .o_position  (out_position),
        .o_target    (out_target),
        .o_known     (out_known),
        .o_busy_res  (out_busy),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clip_pos(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (POS_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic t_result follow_tick(t_action act, logic zero,
                                            logic signed [FIELD_W-1:0] goal);
        t_result r;
        longint  g;
        longint  d;
        longint  p;
        longint  lim;
        longint  u;
        logic    busy;
        g = clip_pos(longint'(goal));
        lim = longint'(mdl_step);
        u = longint'(mdl_travel);
        if (zero) begin
            mdl_pos = 0;
            mdl_tgt = 0;
            mdl_known = 1'b1;
        end
        case (act) inside
            ACT_GOTO, ACT_HOLD: begin
                if (act == ACT_GOTO) begin
                    mdl_tgt = g;
                end
                d = mdl_tgt - mdl_pos;
                if (d > lim) d = lim;
                if (d < -lim) d = -lim;
                mdl_pos = clip_pos(mdl_pos + d);
                busy = (mdl_pos != mdl_tgt);
            end
            ACT_JOG: begin
                // zero goal counts as positive direction
                p = (g < 0) ? mdl_pos - lim : mdl_pos + lim;
                if (p < -2 * u) p = -2 * u;
                if (p > u) p = u;
                mdl_pos = clip_pos(p);
                mdl_tgt = mdl_pos;
                busy = 1'b1;
            end
            default: begin
                mdl_tgt = mdl_pos;
                busy = 1'b0;
            end
        endcase
        r.position = FIELD_W'(mdl_pos);
        r.target   = FIELD_W'(mdl_tgt);
        r.known    = mdl_known;
        r.busy_res = busy;
        return r;
    endfunction

    // driver: next request goes out at the falling edge once the last one was taken
    always @(negedge i_clk) begin
        t_pending_tick t;
        if (rst_n && (!tick_valid || tick_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                tick_valid <= 1'b0;
            end else if (tick_q.size() > 0) begin
                t = tick_q.pop_front();
                tick_action <= t.act;
                tick_zero   <= t.zero;
                tick_goal   <= t.goal;
                tick_valid  <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                tick_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 150;
        end
        if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(1, 60);
        end else begin
            rx_mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ready <= 1'b0;
        end else begin
            case (rx_mode)
                2: res_ready <= $urandom_range(0, 1);
                3: res_ready <= ($urandom_range(0, 3) == 0);
                default: res_ready <= 1'b1;
            endcase
        end
    end

    // monitor: predict on every accepted request, check every accepted result
    always @(posedge i_clk) begin
        t_result w;
        if (!rst_n) begin
            tick_taken = 1'b0;
        end else begin
            tick_taken = tick_valid && in_ready;
            if (tick_taken) begin
                motion_want_q.push_back(follow_tick(t_action'(tick_action), tick_zero,
                                                    tick_goal));
            end
            if (out_valid && res_ready) begin
                if (motion_want_q.size() == 0) begin
                    $display("%0t unexpected result: position %0d target %0d", $time,
                             out_position, out_target);
                    fail_count++;
                end else begin
                    w = motion_want_q.pop_front();
                    if (out_position !== w.position) begin
                        $display("%0t position mismatch: expected %0d actual %0d", $time,
                                 w.position, out_position);
                        fail_count++;
                    end
                    if (out_target !== w.target) begin
                        $display("%0t target mismatch: expected %0d actual %0d", $time,
                                 w.target, out_target);
                        fail_count++;
                    end
                    if (out_known !== w.known) begin
                        $display("%0t known mismatch: expected %0d actual %0d", $time,
                                 w.known, out_known);
                        fail_count++;
                    end
                    if (out_busy !== w.busy_res) begin
                        $display("%0t busy mismatch: expected %0d actual %0d", $time,
                                 w.busy_res, out_busy);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic push_tick(t_action act, logic zero, logic signed [FIELD_W-1:0] goal);
        t_pending_tick t;
        t.act = act;
        t.zero = zero;
        t.goal = goal;
        tick_q.push_back(t);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_MAX_STEP: mdl_step = data[15:0];
            REG_USABLE:   mdl_travel = data[21:0];
            REG_START_POS: begin
                mdl_pos = clip_pos(longint'($signed(data[23:0])));
                mdl_tgt = mdl_pos;
            end
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait until the sender is empty and every result has been taken
    task automatic drain;
        while (tick_q.size() != 0 || tick_valid || motion_want_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_config;
        logic [APB_DATA_W-1:0] junk;
        junk = $urandom;
        case ($urandom_range(0, 5))
            0: apb_write(REG_MAX_STEP, {junk[15:0], 16'd0});
            1: apb_write(REG_MAX_STEP, {junk[15:0], 16'd1});
            2: apb_write(REG_MAX_STEP, {junk[15:0], 16'hFFFF});
            3: apb_write(REG_MAX_STEP, 32'(MAX_STEP_RESET));
            4: apb_write(REG_MAX_STEP, 32'($urandom_range(1, 300)));
            default: apb_write(REG_MAX_STEP, {junk[15:0], 16'($urandom)});
        endcase
        case ($urandom_range(0, 4))
            0: apb_write(REG_USABLE, {junk[9:0], 22'd0});
            1: apb_write(REG_USABLE, 32'd1);
            2: apb_write(REG_USABLE, {junk[9:0], 22'h3FFFFF});
            3: apb_write(REG_USABLE, 32'($urandom_range(1, 5000)));
            default: apb_write(REG_USABLE, {junk[9:0], 22'($urandom)});
        endcase
        case ($urandom_range(0, 7))
            0: apb_write(REG_START_POS, {junk[7:0], 24'h800000});
            1: apb_write(REG_START_POS, {junk[7:0], 24'h7FFFFF});
            2: apb_write(REG_START_POS, 32'd0);
            3: apb_write(REG_START_POS, {junk[7:0], 24'($urandom)});
            4: apb_write(REG_START_POS, 32'($urandom_range(0, 4000)) - 32'd2000);
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0) begin
            apb_write(REG_UNUSED, $urandom);
        end
    endtask

    function automatic logic signed [FIELD_W-1:0] near_goal(longint base, longint span);
        longint v;
        v = base + longint'($urandom_range(0, 32'(2 * span))) - span;
        return FIELD_W'(clip_pos(v));
    endfunction

    // mostly goto-then-hold runs and jog runs, some stops, zeroing and noise
    task automatic queue_random_ticks(int n);
        int                        count;
        int                        k;
        int                        i;
        longint                    span;
        longint                    last_goal;
        logic signed [FIELD_W-1:0] g;
        count = 0;
        last_goal = 0;
        span = 4 * longint'(mdl_step) + 8;
        while (count < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    if ($urandom_range(0, 3) == 0) begin
                        g = FIELD_W'($urandom);
                    end else begin
                        g = near_goal(last_goal, span);
                    end
                    last_goal = longint'(g);
                    push_tick(ACT_GOTO, ($urandom_range(0, 15) == 0), g);
                    k = $urandom_range(0, 12);
                    for (i = 0; i < k; i++) begin
                        push_tick(ACT_HOLD, 1'b0, FIELD_W'($urandom));
                    end
                    count += k + 1;
                end
                4, 5: begin
                    k = $urandom_range(1, 10);
                    for (i = 0; i < k; i++) begin
                        case ($urandom_range(0, 3))
                            0: g = '0;
                            1: g = FIELD_W'($urandom) | 24'h800000;
                            2: g = FIELD_W'($urandom) & 24'h7FFFFF;
                            default: g = FIELD_W'($urandom);
                        endcase
                        push_tick(ACT_JOG, 1'b0, g);
                    end
                    count += k;
                end
                6: begin
                    push_tick(ACT_STOP, 1'b0, FIELD_W'($urandom));
                    count++;
                end
                7: begin
                    push_tick(t_action'($urandom_range(0, 3)), 1'b1, FIELD_W'($urandom));
                    last_goal = 0;
                    count++;
                end
                8: begin
                    push_tick(ACT_HOLD, 1'b0, FIELD_W'($urandom));
                    count++;
                end
                default: begin
                    push_tick(t_action'($urandom_range(0, 3)), ($urandom_range(0, 7) == 0),
                              FIELD_W'($urandom));
                    count++;
                end
            endcase
        end
    endtask

    initial begin
        int ph;
        mdl_pos = 0;
        mdl_tgt = 0;
        mdl_known = 1'b0;
        mdl_step = MAX_STEP_RESET;
        mdl_travel = USABLE_RESET;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // reset settings: slew limit, arrival, range extremes, jog directions, zeroing
        push_tick(ACT_STOP, 1'b0, 24'sd0);
        push_tick(ACT_HOLD, 1'b0, 24'sd0);
        push_tick(ACT_GOTO, 1'b0, 24'sd100);
        push_tick(ACT_HOLD, 1'b0, 24'sd0);
        push_tick(ACT_HOLD, 1'b0, 24'sd0);
        push_tick(ACT_GOTO, 1'b0, 24'h7FFFFF);
        push_tick(ACT_GOTO, 1'b0, 24'h800000);
        push_tick(ACT_JOG, 1'b0, 24'sd0);
        push_tick(ACT_JOG, 1'b0, -24'sd1);
        push_tick(ACT_JOG, 1'b0, 24'h7FFFFF);
        push_tick(ACT_JOG, 1'b0, 24'h800000);
        push_tick(ACT_STOP, 1'b1, 24'h800000);
        push_tick(ACT_HOLD, 1'b1, 24'sd0);
        push_tick(ACT_GOTO, 1'b1, 24'sd50);
        push_tick(ACT_JOG, 1'b1, -24'sd5);
        drain();

        // zero step and zero travel, plus a write to an unmapped index
        apb_write(REG_UNUSED, $urandom);
        apb_write(REG_MAX_STEP, 32'hABCD_0000);
        apb_write(REG_USABLE, 32'd0);
        push_tick(ACT_GOTO, 1'b0, 24'sd500);
        push_tick(ACT_HOLD, 1'b0, 24'sd0);
        push_tick(ACT_JOG, 1'b0, 24'sd1);
        push_tick(ACT_JOG, 1'b0, -24'sd1);
        push_tick(ACT_STOP, 1'b0, 24'sd0);
        drain();

        // largest step and travel from both ends of the position range
        apb_write(REG_MAX_STEP, 32'h0000_FFFF);
        apb_write(REG_USABLE, 32'h003F_FFFF);
        apb_write(REG_START_POS, 32'h5A7F_FFFF);
        push_tick(ACT_JOG, 1'b0, 24'sd3);
        push_tick(ACT_GOTO, 1'b0, 24'h800000);
        push_tick(ACT_HOLD, 1'b0, 24'sd0);
        drain();
        apb_write(REG_START_POS, 32'hFF80_0000);
        push_tick(ACT_JOG, 1'b0, -24'sd7);
        push_tick(ACT_JOG, 1'b0, 24'sd0);
        drain();

        for (ph = 0; ph < 6; ph++) begin
            random_config();
            queue_random_ticks(290);
            // receiver holds off while the sender still has plenty queued
            if (ph == 1 || ph == 4) begin
                hold_req++;
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && motion_want_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
